// ===== hdl/gdoc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and calendar functions for the date/ordinal converter.
package gdoc_pkg;

    localparam int MAX_YEAR = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 22;
    // running day count; holds one past the last day of the largest allowed year
    localparam int ACC_W   = 23;
    localparam int YLEN_W  = 9;

    localparam logic REQ_DATE_TO_ORD = 1'b0;
    localparam logic REQ_ORD_TO_DATE = 1'b1;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    localparam logic [YLEN_W-1:0] YEAR_DAYS      = 9'd365;
    localparam logic [YLEN_W-1:0] LEAP_YEAR_DAYS = 9'd366;

    localparam logic [1:0] C4_INIT   = 2'd1;
    localparam logic [6:0] C100_INIT = 7'd1;
    localparam logic [8:0] C400_INIT = 9'd1;
    localparam logic [6:0] C100_TOP  = 7'd99;
    localparam logic [8:0] C400_TOP  = 9'd399;

    // days in all years before year y; elaboration-time only
    function automatic int days_before_year(input int y);
        int p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    localparam int ORD_LIMIT = days_before_year(MAX_YEAR + 1);

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic out_load;
    } gdoc_cmd_t;

    typedef struct packed {
        logic bad;
        logic year_go;
        logic month_go;
    } gdoc_sts_t;

endpackage

// ===== hdl/gregorian_date_ordinal_converter.sv =====
`timescale 1ns / 1ps
// Top level of the proleptic Gregorian date / day ordinal converter.
//
// Converts a date to a day ordinal (req_type 0) or an ordinal to a date (req_type 1),
// with 0001-01-01 as day 1 and the 4/100/400 leap rule. One item in gives one result
// item out. Out-of-range requests (year outside 1..MAX_YEAR, month outside 1..12,
// day 0, ordinal 0 or past the last day of MAX_YEAR) return all-zero fields with
// bad_input set. A day past the end of its month is not flagged; it simply carries
// into the following month. The datapath walks one year per cycle from year 1, then
// one month per cycle, up to the target year and month (date to ordinal) or while
// the remainder exceeds the year or month length (ordinal to date); a rejected item
// skips both walks. in_stall is high while an item is in work. The result sits in an
// output register, so the next item is taken while the previous result still waits
// on out_stall; a finished item waits in the datapath until that register is free.
module gregorian_date_ordinal_converter
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [gdoc_pkg::YEAR_W-1:0]     in_year,
    input  logic [gdoc_pkg::MONTH_W-1:0]    in_month,
    input  logic [gdoc_pkg::DAY_W-1:0]      in_day,
    input  logic [gdoc_pkg::ORD_W-1:0]      in_ordinal,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gdoc_pkg::ORD_W-1:0]      out_ordinal,
    output logic [gdoc_pkg::YEAR_W-1:0]     out_year,
    output logic [gdoc_pkg::MONTH_W-1:0]    out_month,
    output logic [gdoc_pkg::DAY_W-1:0]      out_day,
    output logic                            bad_input
);

    gdoc_pkg::gdoc_cmd_t cmd;
    gdoc_pkg::gdoc_sts_t sts;

    // sequencer: owns the handshakes and walks the datapath through years then months
    gdoc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath: leap counters, day accumulator and the result register
    gdoc_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .in_year     (in_year),
        .in_month    (in_month),
        .in_day      (in_day),
        .in_ordinal  (in_ordinal),
        .out_ordinal (out_ordinal),
        .out_year    (out_year),
        .out_month   (out_month),
        .out_day     (out_day),
        .bad_input   (bad_input)
    );

endmodule

// ===== hdl/gdoc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the converter: input handshake, year walk, month walk, result hand-off.
module gdoc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output gdoc_pkg::gdoc_cmd_t cmd,
    input  gdoc_pkg::gdoc_sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEARS,
        ST_MONTHS,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_YEARS;
                end
            end
            ST_YEARS:
            begin
                priority if (sts.bad)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.year_go)
                begin
                    cmd.year_step = 1'b1;
                end
                else
                begin
                    state_next = ST_MONTHS;
                end
            end
            ST_MONTHS:
            begin
                if (sts.month_go)
                begin
                    cmd.month_step = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // an accepted item starts the year walk
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_YEARS))
        else $error("accepted item did not start conversion");

    // a loaded result shows valid on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded but not presented");

endmodule

// ===== hdl/gdoc_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: captured request, year and month counters, day accumulator, result registers.
module gdoc_dpath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  gdoc_pkg::gdoc_cmd_t                cmd,
    output gdoc_pkg::gdoc_sts_t                sts,
    input  logic                               req_type,
    input  logic [gdoc_pkg::YEAR_W-1:0]        in_year,
    input  logic [gdoc_pkg::MONTH_W-1:0]       in_month,
    input  logic [gdoc_pkg::DAY_W-1:0]         in_day,
    input  logic [gdoc_pkg::ORD_W-1:0]         in_ordinal,
    output logic [gdoc_pkg::ORD_W-1:0]         out_ordinal,
    output logic [gdoc_pkg::YEAR_W-1:0]        out_year,
    output logic [gdoc_pkg::MONTH_W-1:0]       out_month,
    output logic [gdoc_pkg::DAY_W-1:0]         out_day,
    output logic                               bad_input
);

    logic                          req_reg;
    logic [gdoc_pkg::YEAR_W-1:0]   tgt_year_reg;
    logic [gdoc_pkg::MONTH_W-1:0]  tgt_month_reg;
    logic [gdoc_pkg::DAY_W-1:0]    tgt_day_reg;
    logic [gdoc_pkg::ORD_W-1:0]    tgt_ord_reg;

    logic [gdoc_pkg::YEAR_W-1:0]   y_reg, y_next;
    logic [gdoc_pkg::MONTH_W-1:0]  m_reg, m_next;
    logic [gdoc_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [1:0]                    c4_reg, c4_next;
    logic [6:0]                    c100_reg, c100_next;
    logic [8:0]                    c400_reg, c400_next;

    logic [gdoc_pkg::ORD_W-1:0]    ord_out_reg;
    logic [gdoc_pkg::YEAR_W-1:0]   year_out_reg;
    logic [gdoc_pkg::MONTH_W-1:0]  month_out_reg;
    logic [gdoc_pkg::DAY_W-1:0]    day_out_reg;
    logic                          bad_out_reg;

    logic                          leap;
    logic [gdoc_pkg::YLEN_W-1:0]   ylen;
    logic [gdoc_pkg::DAY_W-1:0]    mlen;
    logic [gdoc_pkg::ACC_W-1:0]    step_len;
    logic                          bad_date;
    logic                          bad_ord;

    assign leap = ((c4_reg == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ylen = leap ? gdoc_pkg::LEAP_YEAR_DAYS : gdoc_pkg::YEAR_DAYS;
    assign mlen = gdoc_pkg::month_days(m_reg, leap);

    assign bad_date = (tgt_year_reg == '0)
                   || (tgt_year_reg > gdoc_pkg::YEAR_W'(gdoc_pkg::MAX_YEAR))
                   || (tgt_month_reg == '0)
                   || (tgt_month_reg > gdoc_pkg::MONTH_LAST)
                   || (tgt_day_reg == '0);
    assign bad_ord  = (tgt_ord_reg == '0)
                   || ({1'b0, tgt_ord_reg} > gdoc_pkg::ACC_W'(gdoc_pkg::ORD_LIMIT));

    always_comb
    begin
        sts.bad = (req_reg == gdoc_pkg::REQ_ORD_TO_DATE) ? bad_ord : bad_date;
        if (req_reg == gdoc_pkg::REQ_ORD_TO_DATE)
        begin
            sts.year_go  = acc_reg > gdoc_pkg::ACC_W'(ylen);
            sts.month_go = (m_reg < gdoc_pkg::MONTH_LAST)
                        && (acc_reg > gdoc_pkg::ACC_W'(mlen));
        end
        else
        begin
            sts.year_go  = y_reg < tgt_year_reg;
            sts.month_go = m_reg < tgt_month_reg;
        end
    end

    always_comb
    begin
        y_next    = y_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        c4_next   = c4_reg;
        c100_next = c100_reg;
        c400_next = c400_reg;
        step_len  = cmd.year_step ? gdoc_pkg::ACC_W'(ylen) : gdoc_pkg::ACC_W'(mlen);
        if (cmd.load)
        begin
            y_next    = gdoc_pkg::YEAR_W'(1);
            m_next    = gdoc_pkg::MONTH_FIRST;
            acc_next  = (req_type == gdoc_pkg::REQ_ORD_TO_DATE)
                      ? gdoc_pkg::ACC_W'(in_ordinal) : gdoc_pkg::ACC_W'(in_day);
            c4_next   = gdoc_pkg::C4_INIT;
            c100_next = gdoc_pkg::C100_INIT;
            c400_next = gdoc_pkg::C400_INIT;
        end
        else if (cmd.year_step || cmd.month_step)
        begin
            acc_next = (req_reg == gdoc_pkg::REQ_ORD_TO_DATE) ? acc_reg - step_len
                                                              : acc_reg + step_len;
            if (cmd.year_step)
            begin
                y_next    = y_reg + 1'b1;
                c4_next   = c4_reg + 1'b1;
                c100_next = (c100_reg == gdoc_pkg::C100_TOP) ? 7'd0 : c100_reg + 1'b1;
                c400_next = (c400_reg == gdoc_pkg::C400_TOP) ? 9'd0 : c400_reg + 1'b1;
            end
            else
            begin
                m_next = m_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_type;
            tgt_year_reg  <= in_year;
            tgt_month_reg <= in_month;
            tgt_day_reg   <= in_day;
            tgt_ord_reg   <= in_ordinal;
        end
        y_reg    <= y_next;
        m_reg    <= m_next;
        acc_reg  <= acc_next;
        c4_reg   <= c4_next;
        c100_reg <= c100_next;
        c400_reg <= c400_next;
        if (cmd.out_load)
        begin
            ord_out_reg   <= '0;
            year_out_reg  <= '0;
            month_out_reg <= '0;
            day_out_reg   <= '0;
            bad_out_reg   <= sts.bad;
            if (!sts.bad)
            begin
                if (req_reg == gdoc_pkg::REQ_ORD_TO_DATE)
                begin
                    year_out_reg  <= y_reg;
                    month_out_reg <= m_reg;
                    day_out_reg   <= acc_reg[gdoc_pkg::DAY_W-1:0];
                end
                else
                begin
                    ord_out_reg <= acc_reg[gdoc_pkg::ORD_W-1:0];
                end
            end
        end
    end

    assign out_ordinal = ord_out_reg;
    assign out_year    = year_out_reg;
    assign out_month   = month_out_reg;
    assign out_day     = day_out_reg;
    assign bad_input   = bad_out_reg;

    // month walk never runs past December
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.month_step |-> (m_reg < gdoc_pkg::MONTH_LAST))
        else $error("month counter stepped past December");

    // the remainder left for a decoded date is a real day of the month
    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !sts.bad && (req_reg == gdoc_pkg::REQ_ORD_TO_DATE))
        |-> ((acc_reg != '0) && (acc_reg <= gdoc_pkg::ACC_W'(31))))
        else $error("day remainder out of range");

endmodule
